// File: hdl/lcd_radix_number_writer_core_macros.svh
// Assertion macros used by the checker of this block.
`ifndef LCD_RADIX_NUMBER_WRITER_CORE_MACROS_SVH
`define LCD_RADIX_NUMBER_WRITER_CORE_MACROS_SVH

// Checked at every rising edge once reset is released.
`define LRNW_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lcd radix writer check failed");

// Checked at every rising edge, reset included.
`define LRNW_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("lcd radix writer check failed during reset");

`endif

// File: hdl/lrnw_pkg.sv
package lrnw_pkg;

	localparam int ColW    = 6;
	localparam int RowW    = 8;
	localparam int ValueW  = 31;
	localparam int RadixW  = 6;
	localparam int OffW    = 7;
	localparam int ByteW   = 8;
	localparam int LenW    = 5;
	localparam int NumRows = 4;
	localparam int IdxW    = $clog2(NumRows);

	// Digit count search multiplies a power of the radix that never exceeds the value.
	localparam int PowW = ValueW + RadixW;

	// The divider retires this many quotient bits per cycle.
	localparam int DivW         = 32;
	localparam int DivBitsCycle = 8;
	localparam int DivCycles    = DivW / DivBitsCycle;
	localparam int DivCntW      = $clog2(DivCycles);

	localparam int QueueDepth = 2;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	localparam logic [ByteW-1:0] CmdSetAddr = 8'h80;
	localparam logic [ByteW-1:0] CmdClear   = 8'h01;
	localparam logic [ByteW-1:0] CharBlank  = 8'h20;
	localparam logic [ByteW-1:0] CharDigit  = 8'h30;
	localparam logic [ByteW-1:0] CharLetter = 8'h37;

	localparam logic [RadixW-1:0] MinRadix   = 6'd2;
	localparam logic [RadixW-1:0] DecimalMax = 6'd9;

	localparam logic [OffW-1:0] RowOffReset [NumRows] = '{7'd0, 7'd64, 7'd20, 7'd84};

	// One classified number handed from the front to the back.
	typedef struct packed {
		logic              clear;
		logic [ByteW-1:0]  base;
		logic [ValueW-1:0] value;
		logic [RadixW-1:0] radix;
		logic [LenW-1:0]   len;
	} job_t;

endpackage

// File: hdl/lrnw_front.sv
module lrnw_front import lrnw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IdxW-1:0]   wr_index,
	input  logic [OffW-1:0]   wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ColW-1:0]   column,
	input  logic [RowW-1:0]   row,
	input  logic [ValueW-1:0] value,
	input  logic [RadixW-1:0] radix,
	output logic              job_valid,
	input  logic              job_stall,
	output job_t              job
);

	typedef enum logic [1:0] {F_IDLE, F_COUNT, F_PUSH} fstate_t;

	fstate_t           state_q;
	job_t              job_q;
	logic [PowW-1:0]   pow_q;
	logic [OffW-1:0]   row_off_q [NumRows];
	logic [RadixW-1:0] radix_sat;
	logic              row_out;
	logic [PowW-1:0]   pow_nxt;

	assign radix_sat = (radix < MinRadix) ? MinRadix : radix;
	assign row_out   = |row[RowW-1:IdxW];
	assign pow_nxt   = {{RadixW{1'b0}}, pow_q[ValueW-1:0]} * {{ValueW{1'b0}}, job_q.radix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRows; i++) row_off_q[i] <= RowOffReset[i];
		end else if (wr_en) begin
			row_off_q[wr_index] <= wr_data;
		end
	end

	// The digit count is the number of radix powers not above the value, plus one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			job_q   <= '0;
			pow_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						if (row_out) begin
							job_q.clear <= 1'b1;
							state_q     <= F_PUSH;
						end else begin
							job_q.clear <= 1'b0;
							job_q.base  <= {1'b0, row_off_q[row[IdxW-1:0]]}
								+ {{(ByteW-ColW){1'b0}}, column};
							job_q.value <= value;
							job_q.radix <= radix_sat;
							job_q.len   <= LenW'(1);
							pow_q       <= {{ValueW{1'b0}}, radix_sat};
							state_q     <= F_COUNT;
						end
					end
				end
				F_COUNT: begin
					if (pow_q > {{RadixW{1'b0}}, job_q.value}) begin
						state_q <= F_PUSH;
					end else begin
						pow_q     <= pow_nxt;
						job_q.len <= job_q.len + LenW'(1);
					end
				end
				F_PUSH: begin
					if (!job_stall) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != F_IDLE);
	assign job_valid = (state_q == F_PUSH);
	assign job       = job_q;

endmodule

// File: hdl/lrnw_queue.sv
module lrnw_queue import lrnw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_stall,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_stall,
	output job_t pop_job
);

	job_t             slot_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_stall = (count_q == QCntW'(QueueDepth));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;
	assign pop_job    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			if (push && !pop) count_q <= count_q + QCntW'(1);
			else if (pop && !push) count_q <= count_q - QCntW'(1);
		end
	end

endmodule

// File: hdl/lrnw_back.sv
module lrnw_back import lrnw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_stall,
	input  job_t             job,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             is_data,
	output logic [ByteW-1:0] bus_byte,
	output logic             last
);

	typedef enum logic [2:0] {B_IDLE, B_HEAD, B_BLANK, B_DIV, B_ADDR, B_CHAR} bstate_t;

	bstate_t             state_q;
	job_t                cur_q;
	logic [LenW-1:0]     idx_q;
	logic [DivW-1:0]     div_q;
	logic [RadixW-1:0]   rem_q;
	logic [DivCntW-1:0]  step_q;
	logic [RadixW-1:0]   digit_q;
	logic                out_valid_q;
	logic                is_data_q;
	logic [ByteW-1:0]    bus_byte_q;
	logic                last_q;
	logic [DivW-1:0]     div_nxt;
	logic [RadixW-1:0]   rem_nxt;
	logic [ByteW-1:0]    digit_char;
	logic                out_free;
	logic                emit;

	// Restoring division, several quotient bits per cycle; the remainder stays below the radix.
	always_comb begin
		logic [RadixW:0] r;
		logic [DivW-1:0] d;
		r = {1'b0, rem_q};
		d = div_q;
		for (int i = 0; i < DivBitsCycle; i++) begin
			r = {r[RadixW-1:0], d[DivW-1]};
			d = {d[DivW-2:0], 1'b0};
			if (r >= {1'b0, cur_q.radix}) begin
				r    = r - {1'b0, cur_q.radix};
				d[0] = 1'b1;
			end
		end
		rem_nxt = r[RadixW-1:0];
		div_nxt = d;
	end

	assign digit_char = (digit_q > DecimalMax)
		? {{(ByteW-RadixW){1'b0}}, digit_q} + CharLetter
		: {{(ByteW-RadixW){1'b0}}, digit_q} + CharDigit;

	assign out_free  = !out_valid_q || !out_stall;
	assign job_stall = (state_q != B_IDLE);

	// A new beat is loaded into the output register this cycle.
	assign emit = out_free && (state_q == B_HEAD || state_q == B_BLANK
		|| state_q == B_ADDR || state_q == B_CHAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cur_q       <= '0;
			idx_q       <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			digit_q     <= '0;
			out_valid_q <= 1'b0;
			is_data_q   <= 1'b0;
			bus_byte_q  <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !emit) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						cur_q   <= job;
						state_q <= B_HEAD;
					end
				end
				B_HEAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						is_data_q   <= 1'b0;
						last_q      <= cur_q.clear;
						if (cur_q.clear) begin
							bus_byte_q <= CmdClear;
							state_q    <= B_IDLE;
						end else begin
							bus_byte_q <= CmdSetAddr + cur_q.base
								+ {{(ByteW-LenW){1'b0}}, cur_q.len};
							state_q    <= B_BLANK;
						end
					end
				end
				B_BLANK: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						is_data_q   <= 1'b1;
						bus_byte_q  <= CharBlank;
						last_q      <= 1'b0;
						idx_q       <= cur_q.len;
						div_q       <= {{(DivW-ValueW){1'b0}}, cur_q.value};
						rem_q       <= '0;
						step_q      <= '0;
						state_q     <= B_DIV;
					end
				end
				B_DIV: begin
					div_q  <= div_nxt;
					rem_q  <= rem_nxt;
					step_q <= step_q + DivCntW'(1);
					if (step_q == DivCntW'(DivCycles - 1)) begin
						digit_q <= rem_nxt;
						idx_q   <= idx_q - LenW'(1);
						state_q <= B_ADDR;
					end
				end
				B_ADDR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						is_data_q   <= 1'b0;
						bus_byte_q  <= CmdSetAddr + cur_q.base
							+ {{(ByteW-LenW){1'b0}}, idx_q};
						last_q      <= 1'b0;
						state_q     <= B_CHAR;
					end
				end
				B_CHAR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						is_data_q   <= 1'b1;
						bus_byte_q  <= digit_char;
						last_q      <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= B_IDLE;
						end else begin
							// The quotient left in div_q is the next dividend.
							rem_q   <= '0;
							step_q  <= '0;
							state_q <= B_DIV;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign is_data   = is_data_q;
	assign bus_byte  = bus_byte_q;
	assign last      = last_q;

endmodule

// File: hdl/lcd_radix_number_writer_core.sv
// Renders a number in base 2 to 36 (larger bases continue the letter codes) as character-LCD
// bus writes: a set-address beat past the field, a blank, then an address and a character
// beat per digit from least to most significant; a row above three gives one clear beat.
// The front counts digits with one multiply per cycle and hands a job through a two-entry
// queue, so it counts the next number while the back emits. The back runs a restoring
// divider per digit (eight quotient bits a cycle) before its address and character beats,
// and that divider sets the sustained rate. Row offsets reset to 0, 64, 20 and 84.
module lcd_radix_number_writer_core import lrnw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IdxW-1:0]   wr_index,
	input  logic [OffW-1:0]   wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ColW-1:0]   column,
	input  logic [RowW-1:0]   row,
	input  logic [ValueW-1:0] value,
	input  logic [RadixW-1:0] radix,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              is_data,
	output logic [ByteW-1:0]  bus_byte,
	output logic              last
);

	logic fq_valid;
	logic fq_stall;
	job_t fq_job;
	logic qb_valid;
	logic qb_stall;
	job_t qb_job;

	lrnw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.column    (column),
		.row       (row),
		.value     (value),
		.radix     (radix),
		.job_valid (fq_valid),
		.job_stall (fq_stall),
		.job       (fq_job)
	);

	lrnw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_stall (fq_stall),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_stall  (qb_stall),
		.pop_job    (qb_job)
	);

	lrnw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_stall (qb_stall),
		.job       (qb_job),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_data   (is_data),
		.bus_byte  (bus_byte),
		.last      (last)
	);

endmodule

// File: hdl/lrnw_checker.sv
`include "lcd_radix_number_writer_core_macros.svh"

module lrnw_checker import lrnw_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic             is_data,
	input logic [ByteW-1:0] bus_byte,
	input logic             last
);

	`LRNW_ASSERT_ALWAYS(a_no_beat_in_reset, clk, !arst_n |-> !out_valid)

	`LRNW_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(is_data) && $stable(bus_byte) && $stable(last))

	// A command beat ends a number only when it is the clear command; a wrapped address
	// command can carry the same byte but never ends the sequence.
	`LRNW_ASSERT(a_clear_is_last, clk, arst_n, out_valid && !is_data && last |-> bus_byte == CmdClear)

	// Address commands and the leading blank always have a digit after them.
	`LRNW_ASSERT(a_addr_not_last, clk, arst_n, out_valid && ((!is_data && bus_byte != CmdClear) || (is_data && bus_byte == CharBlank)) |-> !last)

endmodule

bind lcd_radix_number_writer_core lrnw_checker u_lrnw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.is_data   (is_data),
	.bus_byte  (bus_byte),
	.last      (last)
);
